// File: design/brlm_pkg.sv
// Shared types, constants and register codes of the border ring luminosity mean unit.
`timescale 1ns / 1ps
package brlm_pkg;

	localparam int MAX_SIDE = 256;
	localparam int SIDE_W = 9;
	localparam int POS_W = $clog2(MAX_SIDE);
	localparam int SKIP_W = 3;
	localparam int CHAN_W = 8;
	localparam int SQ_W = 2 * CHAN_W;
	localparam int PROD_W = 32;
	localparam int LUMA_W = 16;
	localparam int SUM_W = 26;
	localparam int CNT_W = 10;
	localparam int MEAN_W = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [15:0] W_RED = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE = 16'd4731;
	localparam logic [15:0] FULL_SQ = 16'd65025;
	localparam logic [CHAN_W-1:0] OPAQUE = 8'hff;

	// Reciprocal of the full-scale square, scaled by two to the power RECIP_SHIFT.
	localparam logic [31:0] RECIP = 32'd2164359682;
	localparam int RECIP_SHIFT = 47;

	localparam logic [SIDE_W-1:0] WIDTH_RESET = 9'd256;
	localparam logic [SIDE_W-1:0] HEIGHT_RESET = 9'd256;
	localparam logic [SKIP_W-1:0] SKIP_RESET = 3'd5;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W = $clog2(Q_DEPTH);

	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		REG_WIDTH = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SKIP = 2'd2
	} brlm_reg_t;

	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
		logic [SKIP_W-1:0] skip;
	} brlm_cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic transparent;
	} brlm_totals_t;

	typedef struct packed {
		logic ring;
		logic opaque;
		logic last;
		logic start;
	} brlm_tag_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} brlm_back_state_t;

endpackage

// File: design/brlm_front.sv
// Front part: position tracking, ring test, pixel luminosity pipeline and frame totals.
`timescale 1ns / 1ps
module brlm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  brlm_pkg::brlm_cfg_t         cfg,
	input  logic                        push,
	output logic                        full,
	input  logic [31:0]                 pixel_argb,
	input  logic                        frame_start,
	output logic                        totals_push,
	output brlm_pkg::brlm_totals_t      totals,
	input  logic                        totals_full
);
	import brlm_pkg::*;

	logic adv;
	logic accept;

	logic [SIDE_W-1:0] w_c;
	logic [SIDE_W-1:0] h_c;
	logic [POS_W-1:0] base_col;
	logic [POS_W-1:0] base_row;
	logic [POS_W-1:0] x_c;
	logic [POS_W-1:0] y_c;
	logic [SIDE_W:0] xs_c;
	logic [SIDE_W:0] ys_c;
	logic [SIDE_W-1:0] x1_c;
	logic [SIDE_W-1:0] y1_c;
	logic inside_c;
	logic on_edge_c;
	logic row_end_c;
	brlm_tag_t tag_c;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	brlm_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [SQ_W-1:0] sq_r_s1, sq_g_s1, sq_b_s1;
	logic [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	logic [PROD_W-1:0] acc_s3;
	logic [PROD_W-1:0] acc_s4;
	logic [LUMA_W-1:0] est_s4;
	logic [LUMA_W-1:0] est_s5;
	logic [LUMA_W:0] rem_s5;
	logic [LUMA_W-1:0] luma_s6;

	logic [2*PROD_W-1:0] recip_prod;
	logic [PROD_W-1:0] back_prod;
	logic [PROD_W-1:0] rem_full;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic seen_q;
	logic [SUM_W-1:0] sum_base;
	logic [CNT_W-1:0] cnt_base;
	logic seen_base;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] cnt_new;
	logic seen_new;

	assign adv = !(v_s6 && tag_s6.last && totals_full);
	assign full = !adv;
	assign accept = push && adv;

	always_comb begin
		if (cfg.width == '0) begin
			w_c = SIDE_W'(1);
		end else if (cfg.width > SIDE_W'(MAX_SIDE)) begin
			w_c = SIDE_W'(MAX_SIDE);
		end else begin
			w_c = cfg.width;
		end
		if (cfg.height == '0) begin
			h_c = SIDE_W'(1);
		end else if (cfg.height > SIDE_W'(MAX_SIDE)) begin
			h_c = SIDE_W'(MAX_SIDE);
		end else begin
			h_c = cfg.height;
		end
	end

	always_comb begin
		base_col = frame_start ? '0 : col_q;
		base_row = frame_start ? '0 : row_q;
		if ({1'b0, base_col} >= w_c) begin
			x_c = POS_W'(w_c - SIDE_W'(1));
		end else begin
			x_c = base_col;
		end
		if ({1'b0, base_row} >= h_c) begin
			y_c = POS_W'(h_c - SIDE_W'(1));
		end else begin
			y_c = base_row;
		end
		xs_c = (SIDE_W + 1)'(x_c) + (SIDE_W + 1)'(cfg.skip);
		ys_c = (SIDE_W + 1)'(y_c) + (SIDE_W + 1)'(cfg.skip);
		x1_c = SIDE_W'(x_c) + SIDE_W'(1);
		y1_c = SIDE_W'(y_c) + SIDE_W'(1);
		inside_c = (x_c >= POS_W'(cfg.skip)) && (xs_c < (SIDE_W + 1)'(w_c))
			&& (y_c >= POS_W'(cfg.skip)) && (ys_c < (SIDE_W + 1)'(h_c));
		on_edge_c = (x_c == POS_W'(cfg.skip)) || (y_c == POS_W'(cfg.skip))
			|| (xs_c + (SIDE_W + 1)'(1) == (SIDE_W + 1)'(w_c))
			|| (ys_c + (SIDE_W + 1)'(1) == (SIDE_W + 1)'(h_c));
		row_end_c = x1_c >= w_c;
		tag_c.ring = inside_c && on_edge_c;
		tag_c.opaque = pixel_argb[31:24] == OPAQUE;
		tag_c.last = row_end_c && (y1_c >= h_c);
		tag_c.start = frame_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (tag_c.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end_c) begin
				col_q <= '0;
				row_q <= POS_W'(y1_c);
			end else begin
				col_q <= POS_W'(x1_c);
				row_q <= y_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign recip_prod = (2 * PROD_W)'(acc_s3) * (2 * PROD_W)'(RECIP);
	assign back_prod = PROD_W'(est_s4) * PROD_W'(FULL_SQ);
	assign rem_full = acc_s4 - back_prod;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_c;
			sq_r_s1 <= SQ_W'(pixel_argb[23:16]) * SQ_W'(pixel_argb[23:16]);
			sq_g_s1 <= SQ_W'(pixel_argb[15:8]) * SQ_W'(pixel_argb[15:8]);
			sq_b_s1 <= SQ_W'(pixel_argb[7:0]) * SQ_W'(pixel_argb[7:0]);

			tag_s2 <= tag_s1;
			pr_s2 <= PROD_W'(sq_r_s1) * PROD_W'(W_RED);
			pg_s2 <= PROD_W'(sq_g_s1) * PROD_W'(W_GREEN);
			pb_s2 <= PROD_W'(sq_b_s1) * PROD_W'(W_BLUE);

			tag_s3 <= tag_s2;
			acc_s3 <= pr_s2 + pg_s2 + pb_s2;

			tag_s4 <= tag_s3;
			acc_s4 <= acc_s3;
			est_s4 <= recip_prod[RECIP_SHIFT+LUMA_W-1:RECIP_SHIFT];

			tag_s5 <= tag_s4;
			est_s5 <= est_s4;
			rem_s5 <= rem_full[LUMA_W:0];

			tag_s6 <= tag_s5;
			luma_s6 <= est_s5 + LUMA_W'(rem_s5 >= (LUMA_W + 1)'(FULL_SQ));
		end
	end

	always_comb begin
		sum_base = tag_s6.start ? '0 : sum_q;
		cnt_base = tag_s6.start ? '0 : cnt_q;
		seen_base = tag_s6.start ? 1'b0 : seen_q;
		sum_new = sum_base;
		cnt_new = cnt_base;
		seen_new = seen_base;
		if (tag_s6.ring) begin
			cnt_new = cnt_base + CNT_W'(1);
			if (tag_s6.opaque) begin
				sum_new = sum_base + SUM_W'(luma_s6);
			end else begin
				seen_new = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			seen_q <= 1'b0;
		end else if (v_s6 && adv) begin
			if (tag_s6.last) begin
				sum_q <= '0;
				cnt_q <= '0;
				seen_q <= 1'b0;
			end else begin
				sum_q <= sum_new;
				cnt_q <= cnt_new;
				seen_q <= seen_new;
			end
		end
	end

	assign totals_push = v_s6 && tag_s6.last && adv;
	assign totals.sum = sum_new;
	assign totals.count = cnt_new;
	assign totals.transparent = seen_new;

endmodule

// File: design/brlm_fifo.sv
// Short queue of frame totals between the front and back parts.
`timescale 1ns / 1ps
module brlm_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  brlm_pkg::brlm_totals_t wr_data,
	output logic                   q_full,
	input  logic                   rd_en,
	output brlm_pkg::brlm_totals_t rd_data,
	output logic                   q_empty
);
	import brlm_pkg::*;

	brlm_totals_t mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full = count_q == (QPTR_W + 1)'(Q_DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// File: design/brlm_back.sv
// Back part: bit-serial mean division and the result output register.
`timescale 1ns / 1ps
module brlm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  brlm_pkg::brlm_totals_t          totals,
	input  logic                            totals_empty,
	output logic                            totals_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic [brlm_pkg::MEAN_W-1:0]     mean_luma,
	output logic                            is_transparent
);
	import brlm_pkg::*;

	brlm_back_state_t state_q;
	brlm_back_state_t state_d;

	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic flag_q;
	logic out_valid_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic out_flag_q;

	logic skip_div;
	logic load_out;
	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic ge;

	assign skip_div = totals.transparent || (totals.count == '0);
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = trial >= {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!totals_empty) begin
					state_d = skip_div ? BK_HOLD : BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_valid_q || pop) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		totals_pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: totals_pop = !totals_empty;
			BK_HOLD: load_out = !out_valid_q || pop;
			default: begin
				totals_pop = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (totals_pop) begin
			quo_q <= skip_div ? '0 : totals.sum;
			rem_q <= '0;
			dvs_q <= totals.count;
			step_q <= '0;
			flag_q <= totals.transparent;
		end else if (state_q == BK_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			step_q <= step_q + DIV_CNT_W'(1);
		end
		if (load_out) begin
			out_mean_q <= quo_q[MEAN_W-1:0];
			out_flag_q <= flag_q;
		end
	end

	assign empty = !out_valid_q;
	assign mean_luma = out_mean_q;
	assign is_transparent = out_flag_q;

endmodule

// File: design/border_ring_luminosity_mean_unit.sv
// Top level of the border ring luminosity mean unit with its configuration registers.
//
// Pixels enter as a queue: a word is taken at a clock edge with push high and full low,
// one word per cycle, in raster order; frame_start marks the first pixel of a frame.
// The result side is a queue as well: while empty is low, mean_luma and is_transparent
// hold the oldest result of a finished frame, and pop high takes it.
// The pixel pipeline runs six stages, set by the chain of square, weight, reciprocal
// and correction multiplies. After the frame's last pixel is taken, the frame result passes
// through the six pipeline stages up to the queue, the back part taking the totals,
// the one-bit-per-cycle divider and the load of the output register. A transparent
// frame or an empty ring skips the divider.
// The divider bounds the frame rate: the back part takes new totals only when idle, and
// two frame totals wait in the queue. Pixels flow at one per cycle until a frame end
// finds the queue full; full then stays high until the back part frees an entry, which
// happens only while the receiver keeps taking results.
// Reset clears positions, sums, queue and output valid flag and loads the registers with
// width 256, height 256 and skip margin 5. Registers are at byte addresses 0, 4 and 8.
`timescale 1ns / 1ps
module border_ring_luminosity_mean_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [brlm_pkg::ADDR_W-1:0]     paddr,
	input  logic [brlm_pkg::DATA_W-1:0]     pwdata,
	output logic [brlm_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            push,
	output logic                            full,
	input  logic [31:0]                     pixel_argb,
	input  logic                            frame_start,
	output logic                            empty,
	input  logic                            pop,
	output logic [brlm_pkg::MEAN_W-1:0]     mean_luma,
	output logic                            is_transparent
);
	import brlm_pkg::*;

	brlm_cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	brlm_totals_t q_wr_data;
	brlm_totals_t q_rd_data;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
			cfg_q.skip <= SKIP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIDTH: cfg_q.width <= pwdata[SIDE_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[SIDE_W-1:0];
				REG_SKIP: cfg_q.skip <= pwdata[SKIP_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH: prdata = DATA_W'(cfg_q.width);
			REG_HEIGHT: prdata = DATA_W'(cfg_q.height);
			REG_SKIP: prdata = DATA_W'(cfg_q.skip);
			default: prdata = '0;
		endcase
	end

	brlm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.pixel_argb  (pixel_argb),
		.frame_start (frame_start),
		.totals_push (q_push),
		.totals      (q_wr_data),
		.totals_full (q_full)
	);

	brlm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	brlm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.totals         (q_rd_data),
		.totals_empty   (q_empty),
		.totals_pop     (q_pop),
		.empty          (empty),
		.pop            (pop),
		.mean_luma      (mean_luma),
		.is_transparent (is_transparent)
	);

	a_transparent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_transparent) |-> (mean_luma == '0))
		else $error("transparent result carries a nonzero mean");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input stalled while the totals queue has room");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame totals pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back part took totals from an empty queue");

endmodule
